### hdl/escape_time_fractal_pixel_assert.svh
// Assertion macros for the checker file of the fractal pixel block
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define EFP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("efp assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define EFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("efp assertion failed");

`endif

### hdl/efp_pkg.sv
// Types, constants and table builders for the escape-time fractal pixel block
package efp_pkg;

    localparam int DIM_MAX    = 4096;
    localparam int ITER_BITS  = 16;
    localparam int FRAC_BITS  = 28;
    localparam int CIDX_BITS  = 10;
    localparam int COORD_W    = 32;
    localparam int PIX_W      = 12;
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int LUT_SCALE  = 2 ** CIDX_BITS;
    localparam int LUT_DEPTH  = LUT_SCALE + 1;
    localparam int LUT_IDX_W  = $clog2(LUT_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 3'd0,
        CFG_X_MIN    = 3'd1,
        CFG_X_MAX    = 3'd2,
        CFG_Y_MIN    = 3'd3,
        CFG_Y_MAX    = 3'd4,
        CFG_WIDTH    = 3'd5,
        CFG_HEIGHT   = 3'd6,
        CFG_MAX_ITER = 3'd7
    } t_cfg_idx;

    localparam logic                      RST_MODE     = 1'b0;
    localparam logic signed [COORD_W-1:0] RST_X_MIN    = -32'sd671088640;
    localparam logic signed [COORD_W-1:0] RST_X_MAX    = 32'sd268435456;
    localparam logic signed [COORD_W-1:0] RST_Y_MIN    = -32'sd268435456;
    localparam logic signed [COORD_W-1:0] RST_Y_MAX    = 32'sd268435456;
    localparam logic [DIM_W-1:0]          RST_WIDTH    = 13'd640;
    localparam logic [DIM_W-1:0]          RST_HEIGHT   = 13'd480;
    localparam logic [ITER_BITS-1:0]      RST_MAX_ITER = 16'd256;

    // Julia constant, rounded to nearest
    localparam longint JULIA_CR_MAG = ((64'd7 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam longint JULIA_CI_MAG = ((64'd27015 << FRAC_BITS) + 64'd50000) / 64'd100000;
    localparam logic signed [COORD_W-1:0] JULIA_CR = COORD_W'(-JULIA_CR_MAG);
    localparam logic signed [COORD_W-1:0] JULIA_CI = COORD_W'(JULIA_CI_MAG);

    // |z|^2 limit of 4 in Q(2F)
    localparam logic [63:0] ESC_BOUND = 64'd4 << (2 * FRAC_BITS);

    typedef struct packed {
        logic signed [COORD_W-1:0] re;
        logic signed [COORD_W-1:0] im;
    } t_point;

    typedef struct packed {
        logic                      mode;
        logic signed [COORD_W-1:0] x_min;
        logic signed [COORD_W-1:0] x_max;
        logic signed [COORD_W-1:0] y_min;
        logic signed [COORD_W-1:0] y_max;
        logic [DIM_W-1:0]          width;
        logic [DIM_W-1:0]          height;
        logic [ITER_BITS-1:0]      max_iter;
    } t_cfg;

    typedef logic [7:0] t_lut [LUT_DEPTH];

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [47:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > 48'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -48'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    // Largest level k with (idx/S)^(p/q) >= (2k-1)/510, exact in integers
    function automatic logic [7:0] gamma_level(input int idx, input int p, input int q);
        logic [127:0] lhs;
        logic [127:0] rhs;
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = 255;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            lhs = 128'd1;
            rhs = 128'd1;
            for (int i = 0; i < p; i++) begin
                lhs = lhs * 128'(idx);
                rhs = rhs * 128'(LUT_SCALE);
            end
            for (int i = 0; i < q; i++) begin
                lhs = lhs * 128'd510;
                rhs = rhs * 128'(2 * mid - 1);
            end
            if (lhs >= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return 8'(lo);
    endfunction

    function automatic t_lut build_lut(input int p, input int q);
        t_lut t;
        for (int i = 0; i < LUT_DEPTH; i++) begin
            t[i] = gamma_level(i, p, q);
        end
        return t;
    endfunction

endpackage

### hdl/efp_front.sv
// Front end: accepts pixels and maps them to points with a serial divider
module efp_front import efp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [PIX_W-1:0] i_pixel_col,
    input  logic [PIX_W-1:0] i_pixel_row,
    output logic             o_push,
    output t_point           o_point,
    input  logic             i_full
);

    localparam int DVD_W = 45;
    localparam int DVS_W = DIM_W + 1;
    localparam int CNT_W = $clog2(DVD_W);

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_MUL  = 6'b000010,
        F_ABS  = 6'b000100,
        F_DIV  = 6'b001000,
        F_FIN  = 6'b010000,
        F_PUSH = 6'b100000
    } t_fstate;

    t_fstate                   r_state, n_state;
    logic [PIX_W-1:0]          r_col, n_col, r_row, n_row;
    logic                      r_axis, n_axis;
    logic signed [46:0]        r_prod, n_prod;
    logic                      r_neg, n_neg;
    logic [DVD_W-1:0]          r_dvd, n_dvd;
    logic [DVS_W-1:0]          r_rem, n_rem;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic signed [COORD_W-1:0] r_px, n_px, r_py, n_py;

    logic [DIM_W-1:0]          dim_raw, dim_c;
    logic [DVS_W-1:0]          divisor;
    logic [PIX_W:0]            odd;
    logic signed [32:0]        diff;
    logic [DVS_W:0]            rem_sh;
    logic                      ge;
    logic [DVD_W:0]            fd_mag;
    logic signed [46:0]        fd;
    logic signed [47:0]        res;

    always_comb begin
        dim_raw = r_axis ? i_cfg.height : i_cfg.width;
        if (dim_raw == '0) begin
            dim_c = DIM_W'(1);
        end else if (dim_raw > DIM_W'(DIM_MAX)) begin
            dim_c = DIM_W'(DIM_MAX);
        end else begin
            dim_c = dim_raw;
        end
        divisor = {dim_c, 1'b0};
        odd     = r_axis ? {r_row, 1'b1} : {r_col, 1'b1};
        diff    = r_axis ? ($signed({i_cfg.y_max[31], i_cfg.y_max})
                           - $signed({i_cfg.y_min[31], i_cfg.y_min}))
                         : ($signed({i_cfg.x_max[31], i_cfg.x_max})
                           - $signed({i_cfg.x_min[31], i_cfg.x_min}));
        rem_sh  = {r_rem, r_dvd[DVD_W-1]};
        ge      = rem_sh >= {1'b0, divisor};
        // floor toward minus infinity for a negative numerator
        fd_mag  = {1'b0, r_dvd} + (DVD_W+1)'(r_neg && (r_rem != '0));
        fd      = r_neg ? -$signed({1'b0, fd_mag}) : $signed({1'b0, fd_mag});
        res     = r_axis ? (48'(i_cfg.y_max) - 48'(fd)) : (48'(i_cfg.x_min) + 48'(fd));
    end

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        n_axis  = r_axis;
        n_prod  = r_prod;
        n_neg   = r_neg;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_px    = r_px;
        n_py    = r_py;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_col   = i_pixel_col;
                    n_row   = i_pixel_row;
                    n_axis  = 1'b0;
                    n_state = F_MUL;
                end
            end
            F_MUL: begin
                n_prod  = 47'($signed({1'b0, odd}) * diff);
                n_state = F_ABS;
            end
            F_ABS: begin
                n_neg   = r_prod[46];
                n_dvd   = r_prod[46] ? DVD_W'(-r_prod) : DVD_W'(r_prod);
                n_rem   = '0;
                n_cnt   = '0;
                n_state = F_DIV;
            end
            F_DIV: begin
                n_rem = ge ? DVS_W'(rem_sh - {1'b0, divisor}) : DVS_W'(rem_sh);
                n_dvd = {r_dvd[DVD_W-2:0], ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    n_state = F_FIN;
                end
            end
            F_FIN: begin
                if (r_axis) begin
                    n_py    = sat32(res);
                    n_state = F_PUSH;
                end else begin
                    n_px    = sat32(res);
                    n_axis  = 1'b1;
                    n_state = F_MUL;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_col  <= n_col;
        r_row  <= n_row;
        r_axis <= n_axis;
        r_prod <= n_prod;
        r_neg  <= n_neg;
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_px   <= n_px;
        r_py   <= n_py;
    end

    assign o_stall    = (r_state != F_IDLE);
    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_point.re = r_px;
    assign o_point.im = r_py;

endmodule

### hdl/efp_queue.sv
// Two-entry point queue between the front end and the iteration engine
module efp_queue import efp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_point i_point,
    output logic   o_full,
    input  logic   i_pop,
    output t_point o_point,
    output logic   o_empty
);

    t_point     r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_fill <= r_fill + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_point;
        end
    end

    assign o_point = r_mem[r_rptr];
    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);

endmodule

### hdl/efp_back.sv
// Back end: escape-time iteration, colour index division and gamma lookup
module efp_back import efp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_empty,
    input  t_point               i_point,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic [ITER_BITS-1:0] o_iteration_count
);

    localparam int   DVD_W    = ITER_BITS + CIDX_BITS;
    localparam int   CNT_W    = $clog2(DVD_W);
    localparam t_lut LUT_RED  = build_lut(3, 5);
    localparam t_lut LUT_GRN  = build_lut(3, 10);
    localparam t_lut LUT_BLU  = build_lut(1, 10);

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_MUL  = 6'b000010,
        B_STEP = 6'b000100,
        B_DIV  = 6'b001000,
        B_ROM  = 6'b010000,
        B_OUT  = 6'b100000
    } t_bstate;

    t_bstate                   r_state, n_state;
    logic signed [COORD_W-1:0] r_zr, n_zr, r_zi, n_zi, r_cr, n_cr, r_ci, n_ci;
    logic [ITER_BITS-1:0]      r_count, n_count;
    logic signed [63:0]        r_sr, n_sr, r_si, n_si, r_pr, n_pr;
    logic [DVD_W-1:0]          r_dvd, n_dvd;
    logic [ITER_BITS-1:0]      r_rem, n_rem;
    logic [CNT_W-1:0]          r_dcnt, n_dcnt;
    logic [LUT_IDX_W-1:0]      r_idx, n_idx;
    logic [7:0]                r_red, n_red, r_grn, n_grn, r_blu, n_blu;
    logic [ITER_BITS-1:0]      r_iter, n_iter;

    logic [63:0]               mag;
    logic                      finish;
    logic [ITER_BITS:0]        rem_sh;
    logic                      ge;

    always_comb begin
        mag    = 64'(r_sr) + 64'(r_si);
        finish = (r_count == i_cfg.max_iter) || (mag > ESC_BOUND);
        rem_sh = {r_rem, r_dvd[DVD_W-1]};
        ge     = rem_sh >= {1'b0, i_cfg.max_iter};
    end

    always_comb begin
        n_state = r_state;
        n_zr    = r_zr;
        n_zi    = r_zi;
        n_cr    = r_cr;
        n_ci    = r_ci;
        n_count = r_count;
        n_sr    = r_sr;
        n_si    = r_si;
        n_pr    = r_pr;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_dcnt  = r_dcnt;
        n_idx   = r_idx;
        n_red   = r_red;
        n_grn   = r_grn;
        n_blu   = r_blu;
        n_iter  = r_iter;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    if (i_cfg.mode) begin
                        n_zr = i_point.re;
                        n_zi = i_point.im;
                        n_cr = JULIA_CR;
                        n_ci = JULIA_CI;
                    end else begin
                        n_zr = '0;
                        n_zi = '0;
                        n_cr = i_point.re;
                        n_ci = i_point.im;
                    end
                    n_count = '0;
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                n_sr    = r_zr * r_zr;
                n_si    = r_zi * r_zi;
                n_pr    = r_zr * r_zi;
                n_state = B_STEP;
            end
            B_STEP: begin
                if (finish) begin
                    if (i_cfg.max_iter == '0) begin
                        n_idx   = '0;
                        n_state = B_ROM;
                    end else begin
                        n_dvd   = {r_count, CIDX_BITS'(0)};
                        n_rem   = '0;
                        n_dcnt  = '0;
                        n_state = B_DIV;
                    end
                end else begin
                    // arithmetic shifts give the floor
                    n_zr    = sat32(48'(r_sr >>> FRAC_BITS) - 48'(r_si >>> FRAC_BITS)
                                    + 48'(r_cr));
                    n_zi    = sat32(48'(r_pr >>> (FRAC_BITS - 1)) + 48'(r_ci));
                    n_count = r_count + 1'b1;
                    n_state = B_MUL;
                end
            end
            B_DIV: begin
                n_rem  = ge ? ITER_BITS'(rem_sh - {1'b0, i_cfg.max_iter})
                            : ITER_BITS'(rem_sh);
                n_dvd  = {r_dvd[DVD_W-2:0], ge};
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == CNT_W'(DVD_W - 1)) begin
                    n_idx   = {r_dvd[LUT_IDX_W-2:0], ge};
                    n_state = B_ROM;
                end
            end
            B_ROM: begin
                n_red   = LUT_RED[r_idx];
                n_grn   = LUT_GRN[r_idx];
                n_blu   = LUT_BLU[r_idx];
                n_iter  = r_count;
                n_state = B_OUT;
            end
            B_OUT: begin
                if (!i_stall) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_zr    <= n_zr;
        r_zi    <= n_zi;
        r_cr    <= n_cr;
        r_ci    <= n_ci;
        r_count <= n_count;
        r_sr    <= n_sr;
        r_si    <= n_si;
        r_pr    <= n_pr;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_dcnt  <= n_dcnt;
        r_idx   <= n_idx;
        r_red   <= n_red;
        r_grn   <= n_grn;
        r_blu   <= n_blu;
        r_iter  <= n_iter;
    end

    assign o_pop             = (r_state == B_IDLE) && !i_empty;
    assign o_valid           = (r_state == B_OUT);
    assign o_red             = r_red;
    assign o_green           = r_grn;
    assign o_blue            = r_blu;
    assign o_iteration_count = r_iter;

endmodule

### hdl/escape_time_fractal_pixel.sv
// Top level of the escape-time fractal pixel block: registers, front, queue, back
//
// Input channel: i_valid / o_stall with i_pixel_col and i_pixel_row. Output channel:
// o_valid / i_stall with o_red, o_green, o_blue and o_iteration_count, one result
// per pixel, in order. Registers are written through i_cfg_we / i_cfg_addr /
// i_cfg_wdata; the user must write them only while the block is idle, which the
// block itself does not enforce. The front end maps a pixel to a point with two
// 45-step serial divisions, then hands it to a two-entry queue and takes the next
// pixel. The back end runs each escape-time step as a multiply, then an update;
// per pixel it pops and iterates, runs a 26-step colour division (skipped when
// the limit is 0), then does lookup and output before it pops the next point.
// The front and back ends work in parallel, decoupled by the queue.
// Reset clears the control state and restores the register defaults (Mandelbrot,
// view -2.5..1 by -1..1, 640x480, 256 iterations). A stalled result holds in the
// output register while the front end keeps filling the queue; once the queue is
// full the front end holds o_stall high.
module escape_time_fractal_pixel import efp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [COORD_W-1:0]   i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PIX_W-1:0]     i_pixel_col,
    input  logic [PIX_W-1:0]     i_pixel_row,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic [ITER_BITS-1:0] o_iteration_count
);

    t_cfg   r_cfg;
    logic   push, full, pop, empty;
    t_point push_point, pop_point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode     <= RST_MODE;
            r_cfg.x_min    <= RST_X_MIN;
            r_cfg.x_max    <= RST_X_MAX;
            r_cfg.y_min    <= RST_Y_MIN;
            r_cfg.y_max    <= RST_Y_MAX;
            r_cfg.width    <= RST_WIDTH;
            r_cfg.height   <= RST_HEIGHT;
            r_cfg.max_iter <= RST_MAX_ITER;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_MODE:     r_cfg.mode     <= i_cfg_wdata[0];
                CFG_X_MIN:    r_cfg.x_min    <= i_cfg_wdata;
                CFG_X_MAX:    r_cfg.x_max    <= i_cfg_wdata;
                CFG_Y_MIN:    r_cfg.y_min    <= i_cfg_wdata;
                CFG_Y_MAX:    r_cfg.y_max    <= i_cfg_wdata;
                CFG_WIDTH:    r_cfg.width    <= i_cfg_wdata[DIM_W-1:0];
                CFG_HEIGHT:   r_cfg.height   <= i_cfg_wdata[DIM_W-1:0];
                CFG_MAX_ITER: r_cfg.max_iter <= i_cfg_wdata[ITER_BITS-1:0];
                default: ;
            endcase
        end
    end

    efp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel_col (i_pixel_col),
        .i_pixel_row (i_pixel_row),
        .o_push      (push),
        .o_point     (push_point),
        .i_full      (full)
    );

    efp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_point (push_point),
        .o_full  (full),
        .i_pop   (pop),
        .o_point (pop_point),
        .o_empty (empty)
    );

    efp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_empty           (empty),
        .i_point           (pop_point),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_red             (o_red),
        .o_green           (o_green),
        .o_blue            (o_blue),
        .o_iteration_count (o_iteration_count)
    );

endmodule

### hdl/efp_checker.sv
// Port-level checker for the fractal pixel block, bound to the top level
`include "escape_time_fractal_pixel_assert.svh"

module efp_checker import efp_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [7:0]           o_red,
    input logic [7:0]           o_green,
    input logic [7:0]           o_blue,
    input logic [ITER_BITS-1:0] o_iteration_count
);

    logic [ITER_BITS+23:0] out_word;

    assign out_word = {o_red, o_green, o_blue, o_iteration_count};

    `EFP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `EFP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(out_word))
    // steeper gamma never gives a brighter channel
    `EFP_ASSERT_NOW(a_gamma_order, i_clk, i_rst_n, o_valid, (o_blue >= o_green) && (o_green >= o_red))
    `EFP_ASSERT_NOW(a_zero_black, i_clk, i_rst_n, o_valid && (o_iteration_count == '0), (out_word[ITER_BITS+23:ITER_BITS] == '0))

endmodule

bind escape_time_fractal_pixel efp_checker u_efp_checker (.*);
